/* rtl/core/grd_pkg.sv */
// ----------------------------------------------------------------------------
// grd_pkg
// shared widths, constants and codes of the grid ray stepper
// ----------------------------------------------------------------------------
package grd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIR_FRAC  = 14;
  localparam int POS_W     = 24;
  localparam int DIR_W     = 16;
  localparam int DIST_W    = 32;
  localparam int CELL_W    = 16;
  localparam int COL_W     = 6;
  localparam int MAP_W     = 9;

  // serial divider: dividend bits, one quotient bit per cycle
  localparam int DIV_W     = 46;
  localparam int DIV_CNT_W = 6;

  // shift-add multiplier: multiplicand and multiplier widths
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 17;

  // square root: one result bit per cycle
  localparam int SQRT_STEPS = 32;

  localparam logic [DIST_W-1:0] SAT = {DIST_W{1'b1}};

  typedef logic [DIST_W-1:0] dist_t;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // register indexes
  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

endpackage

/* rtl/core/grd_div.sv */
// ----------------------------------------------------------------------------
// grd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [grd_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic [grd_pkg::DIV_W-1:0] quotient,
  output logic                      done
);
  import grd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          rem;
  logic [16:0]          trial;
  logic                 q_bit;
  logic [16:0]          diff;

  // trial subtract of the shifted remainder
  assign trial = {rem, quotient[DIV_W-1]};
  assign q_bit = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  // iteration register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= q_bit ? diff[15:0] : trial[15:0];
        quotient <= {quotient[DIV_W-2:0], q_bit};
        cnt      <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/grid_ray_dda_stepper.sv */
// ----------------------------------------------------------------------------
// grid_ray_dda_stepper
// fixed point grid ray traverser, one cell per step item
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries operation, cam_x, cam_y,
//   dir_x, dir_y; operation start loads a ray, operation step moves one cell.
//   every input item gives exactly one result on the output channel
//   (out_valid / out_stall): cell, crossed side, wall distance, texture
//   column and the map bounds flag.
//   cfg_write with cfg_index / cfg_data sets map width and height; write
//   only while idle.
// timing:
//   one item at a time; in_stall is high from transfer until the result
//   is loaded into the output register; the next item is accepted while idle.
//   start: two squares, a square root, two serial divisions, two products,
//   then the send and finish states.
//   step: advance, a serial division, a product, column end and finish;
//   a zero direction or wrong sign skips the division.
// reset: ray state zero except wall_r and col_r, map size 64 by 64, no result pending.
// stall: a finished result waits in the control until the output register
//   frees; a held result stays stable while out_stall is high.
// ----------------------------------------------------------------------------
module grid_ray_dda_stepper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [grd_pkg::MAP_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [grd_pkg::POS_W-1:0]         cam_x,
  input  logic [grd_pkg::POS_W-1:0]         cam_y,
  input  logic signed [grd_pkg::DIR_W-1:0]  dir_x,
  input  logic signed [grd_pkg::DIR_W-1:0]  dir_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [grd_pkg::CELL_W-1:0] cell_x,
  output logic signed [grd_pkg::CELL_W-1:0] cell_y,
  output logic                              crossed_side,
  output logic [grd_pkg::DIST_W-1:0]        wall_distance,
  output logic [grd_pkg::COL_W-1:0]         texture_column,
  output logic                              inside_map
);
  import grd_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQ_X   = 4'd1;
  localparam logic [3:0] ST_SQ_Y   = 4'd2;
  localparam logic [3:0] ST_SQRT   = 4'd3;
  localparam logic [3:0] ST_DIV_X  = 4'd4;
  localparam logic [3:0] ST_DIV_Y  = 4'd5;
  localparam logic [3:0] ST_SIDE_X = 4'd6;
  localparam logic [3:0] ST_SIDE_Y = 4'd7;
  localparam logic [3:0] ST_SEND   = 4'd8;
  localparam logic [3:0] ST_ADV    = 4'd9;
  localparam logic [3:0] ST_WALL   = 4'd10;
  localparam logic [3:0] ST_COLM   = 4'd11;
  localparam logic [3:0] ST_CEND   = 4'd12;
  localparam logic [3:0] ST_FIN    = 4'd13;

  localparam logic [MUL_B_W-1:0] POS_ONE = MUL_B_W'(1) << FRAC_BITS;

  logic [3:0]         state;
  logic               first;
  logic [5:0]         cnt;

  logic [MAP_W-1:0]   map_width;
  logic [MAP_W-1:0]   map_height;

  // ray state
  logic [POS_W-1:0]   origin_x;
  logic [POS_W-1:0]   origin_y;
  logic [DIR_W-1:0]   direction_x;
  logic [DIR_W-1:0]   direction_y;
  dist_t              jump_x;
  dist_t              jump_y;
  dist_t              side_x;
  dist_t              side_y;
  logic [CELL_W-1:0]  cur_x;
  logic [CELL_W-1:0]  cur_y;
  logic               sign_x;
  logic               sign_y;
  logic               last_side;
  dist_t              wall_r;
  logic [COL_W-1:0]   col_r;

  // serial units
  logic [MUL_A_W+MUL_B_W:0] prod;
  logic [MUL_A_W-1:0]       mcand;
  logic [MUL_A_W:0]         mul_add;
  logic [31:0]              sumsq;
  logic [63:0]              rad;
  logic [34:0]              sq_rem;
  logic [31:0]              root;
  logic [34:0]              sq_sh;
  logic [34:0]              sq_trial;
  logic                     sq_ge;

  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [15:0]          div_divisor;
  logic [DIV_W-1:0]     div_q;
  logic                 div_done;

  logic [15:0]          mag_x;
  logic [15:0]          mag_y;
  logic                 adv_x;
  logic [MUL_B_W-1:0]   side_mlr_x;
  logic [MUL_B_W-1:0]   side_mlr_y;

  logic [CELL_W-1:0]    sel_cell;
  logic [POS_W-1:0]     sel_pos;
  logic [DIR_W-1:0]     sel_dir;
  logic [15:0]          sel_mag;
  logic                 sel_neg;
  logic [POS_W-1:0]     oth_pos;
  logic [DIR_W-1:0]     oth_dir;
  logic [15:0]          oth_mag;
  logic [33:0]          num;
  logic [33:0]          num_abs;
  logic                 wall_skip;
  dist_t                wall_skip_val;
  dist_t                wall_sat;
  logic [29:0]          col_t;
  logic                 cell_inside;

  function automatic dist_t add_sat(dist_t a, dist_t b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == SAT || s[DIST_W]) return SAT;
    return s[DIST_W-1:0];
  endfunction

  assign in_stall = (state != ST_IDLE);

  // magnitudes of the stored direction
  assign mag_x = direction_x[DIR_W-1] ? 16'(-direction_x) : direction_x;
  assign mag_y = direction_y[DIR_W-1] ? 16'(-direction_y) : direction_y;

  // shift-add multiplier step
  assign mul_add = {1'b0, prod[MUL_A_W+MUL_B_W-1:MUL_B_W]}
                 + (prod[0] ? {1'b0, mcand} : {(MUL_A_W+1){1'b0}});

  // square root step, two radicand bits per cycle
  assign sq_sh    = {sq_rem[32:0], rad[63:62]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // first side distance multipliers
  assign side_mlr_x = sign_x ? {1'b0, origin_x[FRAC_BITS-1:0]}
                             : POS_ONE - {1'b0, origin_x[FRAC_BITS-1:0]};
  assign side_mlr_y = sign_y ? {1'b0, origin_y[FRAC_BITS-1:0]}
                             : POS_ONE - {1'b0, origin_y[FRAC_BITS-1:0]};

  assign adv_x = (side_x < side_y);

  // crossed and other axis after the advance
  assign sel_cell = last_side ? cur_y : cur_x;
  assign sel_pos  = last_side ? origin_y : origin_x;
  assign sel_dir  = last_side ? direction_y : direction_x;
  assign sel_mag  = last_side ? mag_y : mag_x;
  assign sel_neg  = last_side ? sign_y : sign_x;
  assign oth_pos  = last_side ? origin_x : origin_y;
  assign oth_dir  = last_side ? direction_x : direction_y;
  assign oth_mag  = last_side ? mag_x : mag_y;

  // signed distance from the origin to the crossed side
  assign num = {{2{sel_cell[CELL_W-1]}}, sel_cell, {FRAC_BITS{1'b0}}}
             - {{(34-POS_W){1'b0}}, sel_pos}
             + (sel_neg ? 34'(POS_ONE) : 34'd0);
  assign num_abs = num[33] ? 34'(-num) : num;

  // zero direction saturates, wrong sign gives zero
  assign wall_skip = (sel_mag == 16'd0) ||
                     ((num != 34'd0) && (num[33] != sel_dir[DIR_W-1]));
  assign wall_skip_val = (sel_mag == 16'd0) ? SAT : '0;
  assign wall_sat = (|div_q[DIV_W-1:DIST_W]) ? SAT : div_q[DIST_W-1:0];

  // hit point fraction on the other axis
  assign col_t = {oth_pos[FRAC_BITS-1:0], {DIR_FRAC{1'b0}}}
               + (oth_dir[DIR_W-1] ? 30'(30'd0 - prod[29:0]) : prod[29:0]);

  assign cell_inside = !cur_x[CELL_W-1] && !cur_y[CELL_W-1] &&
                       (cur_x[CELL_W-1:MAP_W] == '0) && (cur_x[MAP_W-1:0] < map_width) &&
                       (cur_y[CELL_W-1:MAP_W] == '0) && (cur_y[MAP_W-1:0] < map_height);

  // divider control
  assign div_start = first && ((state == ST_DIV_X) || (state == ST_DIV_Y) ||
                               ((state == ST_WALL) && !wall_skip));
  assign div_dividend = (state == ST_WALL) ? {num_abs[31:0], {DIR_FRAC{1'b0}}}
                                           : {{(DIV_W-32){1'b0}}, root};
  assign div_divisor = (state == ST_DIV_X) ? mag_x :
                       (state == ST_DIV_Y) ? mag_y : sel_mag;

  grd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // sequencer and ray state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      first       <= 1'b0;
      cnt         <= '0;
      out_valid   <= 1'b0;
      map_width   <= MAP_W'(64);
      map_height  <= MAP_W'(64);
      origin_x    <= '0;
      origin_y    <= '0;
      direction_x <= '0;
      direction_y <= '0;
      jump_x      <= '0;
      jump_y      <= '0;
      side_x      <= '0;
      side_y      <= '0;
      cur_x       <= '0;
      cur_y       <= '0;
      sign_x      <= 1'b0;
      sign_y      <= 1'b0;
      last_side   <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_MAP_WIDTH) map_width <= cfg_data;
        else map_height <= cfg_data;
      end
      // output transfer frees the register unless a new result loads now
      if (out_valid && !out_stall && (state != ST_FIN)) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            first <= 1'b1;
            if (operation == OP_START) begin
              origin_x    <= cam_x;
              origin_y    <= cam_y;
              direction_x <= dir_x;
              direction_y <= dir_y;
              cur_x       <= {{(CELL_W-POS_W+FRAC_BITS){1'b0}}, cam_x[POS_W-1:FRAC_BITS]};
              cur_y       <= {{(CELL_W-POS_W+FRAC_BITS){1'b0}}, cam_y[POS_W-1:FRAC_BITS]};
              sign_x      <= dir_x[DIR_W-1];
              sign_y      <= dir_y[DIR_W-1];
              last_side   <= 1'b0;
              wall_r      <= '0;
              col_r       <= '0;
              state       <= ST_SQ_X;
            end else begin
              state <= ST_ADV;
            end
          end
        end

        ST_SQ_X, ST_SQ_Y, ST_SIDE_X, ST_SIDE_Y, ST_COLM: begin
          if (first) begin
            first <= 1'b0;
            cnt   <= '0;
            case (state)
              ST_SQ_X: begin
                prod  <= {{(MUL_A_W+1){1'b0}}, 1'b0, mag_x};
                mcand <= {16'd0, mag_x};
              end
              ST_SQ_Y: begin
                sumsq <= prod[31:0];
                prod  <= {{(MUL_A_W+1){1'b0}}, 1'b0, mag_y};
                mcand <= {16'd0, mag_y};
              end
              ST_SIDE_X: begin
                jump_y <= (mag_y == 16'd0) ? SAT : div_q[DIST_W-1:0];
                prod   <= {{(MUL_A_W+1){1'b0}}, side_mlr_x};
                mcand  <= jump_x;
              end
              ST_SIDE_Y: begin
                side_x <= (jump_x == SAT) ? SAT : prod[FRAC_BITS+DIST_W-1:FRAC_BITS];
                prod   <= {{(MUL_A_W+1){1'b0}}, side_mlr_y};
                mcand  <= jump_y;
              end
              default: begin
                prod  <= {{(MUL_A_W+1){1'b0}}, 1'b0, oth_mag};
                mcand <= wall_r;
              end
            endcase
          end else begin
            prod <= {1'b0, mul_add, prod[MUL_B_W-1:1]};
            cnt  <= cnt + 1'b1;
            if (cnt == 6'(MUL_B_W - 1)) begin
              first <= 1'b1;
              case (state)
                ST_SQ_X:   state <= ST_SQ_Y;
                ST_SQ_Y:   state <= ST_SQRT;
                ST_SIDE_X: state <= ST_SIDE_Y;
                ST_SIDE_Y: state <= ST_SEND;
                default:   state <= ST_CEND;
              endcase
            end
          end
        end

        ST_SQRT: begin
          if (first) begin
            first  <= 1'b0;
            cnt    <= '0;
            rad    <= {sumsq + prod[31:0], 32'd0};
            sq_rem <= '0;
            root   <= '0;
          end else begin
            rad    <= {rad[61:0], 2'b00};
            sq_rem <= sq_ge ? 35'(sq_sh - sq_trial) : sq_sh;
            root   <= {root[30:0], sq_ge};
            cnt    <= cnt + 1'b1;
            if (cnt == 6'(SQRT_STEPS - 1)) begin
              first <= 1'b1;
              state <= ST_DIV_X;
            end
          end
        end

        ST_DIV_X, ST_DIV_Y: begin
          if (first) begin
            first <= 1'b0;
            if (state == ST_DIV_Y) jump_x <= (mag_x == 16'd0) ? SAT : div_q[DIST_W-1:0];
          end else if (div_done) begin
            first <= 1'b1;
            state <= (state == ST_DIV_X) ? ST_DIV_Y : ST_SIDE_X;
          end
        end

        ST_SEND: begin
          side_y <= (jump_y == SAT) ? SAT : prod[FRAC_BITS+DIST_W-1:FRAC_BITS];
          state  <= ST_FIN;
        end

        ST_ADV: begin
          if (adv_x) begin
            side_x    <= add_sat(side_x, jump_x);
            cur_x     <= cur_x + (sign_x ? {CELL_W{1'b1}} : CELL_W'(1));
            last_side <= 1'b0;
          end else begin
            side_y    <= add_sat(side_y, jump_y);
            cur_y     <= cur_y + (sign_y ? {CELL_W{1'b1}} : CELL_W'(1));
            last_side <= 1'b1;
          end
          first <= 1'b1;
          state <= ST_WALL;
        end

        ST_WALL: begin
          if (first) begin
            if (wall_skip) begin
              wall_r <= wall_skip_val;
              first  <= 1'b1;
              state  <= ST_COLM;
            end else begin
              first  <= 1'b0;
            end
          end else if (div_done) begin
            wall_r <= wall_sat;
            first  <= 1'b1;
            state  <= ST_COLM;
          end
        end

        ST_CEND: begin
          col_r <= col_t[29 -: COL_W];
          state <= ST_FIN;
        end

        ST_FIN: begin
          if (!(out_valid && out_stall)) begin
            cell_x         <= cur_x;
            cell_y         <= cur_y;
            crossed_side   <= last_side;
            wall_distance  <= wall_r;
            texture_column <= col_r;
            inside_map     <= cell_inside;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a finished result with a free output register is loaded at once
  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) && !(out_valid && out_stall) |=> out_valid && (state == ST_IDLE))
    else $error("finished result not loaded");

  // an input transfer makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after input transfer");

  // the divider reports only to a state that waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_X) || (state == ST_DIV_Y) || (state == ST_WALL))
    else $error("divider finished outside a division state");
`endif

endmodule

/* verif/grid_ray_dda_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_ray_dda_checker
// watches both channels of the ray stepper, predicts each result and compares
// ----------------------------------------------------------------------------
module grid_ray_dda_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [grd_pkg::MAP_W-1:0]         cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              operation,
  input  logic [grd_pkg::POS_W-1:0]         cam_x,
  input  logic [grd_pkg::POS_W-1:0]         cam_y,
  input  logic signed [grd_pkg::DIR_W-1:0]  dir_x,
  input  logic signed [grd_pkg::DIR_W-1:0]  dir_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [grd_pkg::CELL_W-1:0] cell_x,
  input  logic signed [grd_pkg::CELL_W-1:0] cell_y,
  input  logic                              crossed_side,
  input  logic [grd_pkg::DIST_W-1:0]        wall_distance,
  input  logic [grd_pkg::COL_W-1:0]         texture_column,
  input  logic                              inside_map,
  output int                                fail_count,
  output int                                pending_hits
);
  import grd_pkg::*;

  typedef struct packed {
    logic signed [CELL_W-1:0] cx;
    logic signed [CELL_W-1:0] cy;
    logic                     side;
    logic [DIST_W-1:0]        wall;
    logic [COL_W-1:0]         col;
    logic                     in_map;
  } hit_t;

  hit_t hit_q[$];

  // predicted ray state
  logic [MAP_W-1:0]         width_r, height_r;
  logic [POS_W-1:0]         org_x, org_y;
  logic signed [DIR_W-1:0]  ray_dx, ray_dy;
  logic [DIST_W-1:0]        jmp_x, jmp_y, side_x, side_y;
  logic signed [CELL_W-1:0] at_x, at_y;
  logic                     neg_x, neg_y, hit_side;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absv(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic logic [DIST_W-1:0] clip(longint unsigned v);
    return v > 64'hFFFF_FFFF ? SAT : v[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] jump_len(longint a, longint b);
    longint unsigned s;
    if (a == 0) return SAT;
    s = absv(a) * absv(a) + absv(b) * absv(b);
    return clip((root64(s << 32) << FRAC_BITS) / (absv(a) << 16));
  endfunction

  function automatic logic [DIST_W-1:0] first_side(logic [POS_W-1:0] p,
                                                   logic [DIST_W-1:0] j, logic n);
    longint unsigned f;
    f = p[FRAC_BITS-1:0];
    if (j == SAT) return SAT;
    if (n) return clip((f * j) >> FRAC_BITS);
    return clip((((64'd1 << FRAC_BITS) - f) * j) >> FRAC_BITS);
  endfunction

  function automatic logic [DIST_W-1:0] add_clip(logic [DIST_W-1:0] a,
                                                 logic [DIST_W-1:0] b);
    if (a == SAT) return SAT;
    return clip(longint'(a) + longint'(b));
  endfunction

  function automatic logic [DIST_W-1:0] perp_dist(longint c, logic [POS_W-1:0] p,
                                                  longint d, logic n);
    longint num;
    num = c * (64'sd1 << FRAC_BITS) - longint'(p);
    if (n) num += 64'sd1 << FRAC_BITS;
    if (d == 0) return SAT;
    if (num != 0 && ((num < 0) != (d < 0))) return '0;
    return clip((absv(num) << DIR_FRAC) / absv(d));
  endfunction

  function automatic logic [COL_W-1:0] tex_col(logic [POS_W-1:0] p,
                                               logic [DIST_W-1:0] w, longint d);
    longint unsigned m, t, f;
    m = longint'(w) * absv(d);
    t = (longint'(p) << DIR_FRAC) + (d < 0 ? 64'd0 - m : m);
    f = (t >> DIR_FRAC) & ((64'd1 << FRAC_BITS) - 1);
    return COL_W'((f * 64) >> FRAC_BITS);
  endfunction

  // advance the predicted ray by one transfer
  task automatic predict_hit(logic op, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic signed [DIR_W-1:0] ddx, logic signed [DIR_W-1:0] ddy);
    hit_t h;
    h.wall = '0;
    h.col  = '0;
    if (op == OP_START) begin
      org_x = px; org_y = py; ray_dx = ddx; ray_dy = ddy;
      jmp_x = jump_len(ddx, ddy);
      jmp_y = jump_len(ddy, ddx);
      at_x = CELL_W'(org_x[POS_W-1:FRAC_BITS]);
      at_y = CELL_W'(org_y[POS_W-1:FRAC_BITS]);
      neg_x = ddx < 0; neg_y = ddy < 0;
      side_x = first_side(org_x, jmp_x, neg_x);
      side_y = first_side(org_y, jmp_y, neg_y);
      hit_side = 1'b0;
    end else begin
      if (side_x < side_y) begin
        side_x = add_clip(side_x, jmp_x);
        at_x = at_x + (neg_x ? -16'sd1 : 16'sd1);
        hit_side = 1'b0;
        h.wall = perp_dist(at_x, org_x, ray_dx, neg_x);
        h.col  = tex_col(org_y, h.wall, ray_dy);
      end else begin
        side_y = add_clip(side_y, jmp_y);
        at_y = at_y + (neg_y ? -16'sd1 : 16'sd1);
        hit_side = 1'b1;
        h.wall = perp_dist(at_y, org_y, ray_dy, neg_y);
        h.col  = tex_col(org_x, h.wall, ray_dx);
      end
    end
    h.cx = at_x;
    h.cy = at_y;
    h.side = hit_side;
    h.in_map = at_x >= 0 && at_y >= 0 && at_x < $signed({7'd0, width_r}) &&
               at_y < $signed({7'd0, height_r});
    hit_q.push_back(h);
  endtask

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    hit_t e;
    if (rst) begin
      width_r = 64; height_r = 64;
      org_x = '0; org_y = '0; ray_dx = '0; ray_dy = '0;
      jmp_x = '0; jmp_y = '0; side_x = '0; side_y = '0;
      at_x = '0; at_y = '0; neg_x = 0; neg_y = 0; hit_side = 0;
      fail_count = 0;
      hit_q.delete();
      pending_hits = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_MAP_WIDTH) width_r = cfg_data;
        else height_r = cfg_data;
      end
      if (in_valid && !in_stall) predict_hit(operation, cam_x, cam_y, dir_x, dir_y);
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected: cell %0d,%0d", $time,
                   cell_x, cell_y);
        end else begin
          e = hit_q.pop_front();
          if (e.cx !== cell_x || e.cy !== cell_y || e.side !== crossed_side ||
              e.wall !== wall_distance || e.col !== texture_column ||
              e.in_map !== inside_map) begin
            fail_count++;
            $display("%0t: mismatch expected cell %0d,%0d side %0d wall %h col %0d in %0d",
                     $time, e.cx, e.cy, e.side, e.wall, e.col, e.in_map);
            $display("%0t:          actual   cell %0d,%0d side %0d wall %h col %0d in %0d",
                     $time, cell_x, cell_y, crossed_side, wall_distance,
                     texture_column, inside_map);
          end
        end
      end
      pending_hits = hit_q.size();
    end
  end

endmodule

/* verif/tb_grid_ray_dda_stepper.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_ray_dda_stepper
// drives ray starts and cell steps with bursty traffic and random output
// stalls across several map sizes; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_grid_ray_dda_stepper;
  import grd_pkg::*;

  logic                     clk, rst;
  logic                     cfg_write, cfg_index;
  logic [MAP_W-1:0]         cfg_data;
  logic                     in_valid, in_stall, operation;
  logic [POS_W-1:0]         cam_x, cam_y;
  logic signed [DIR_W-1:0]  dir_x, dir_y;
  logic                     out_valid, out_stall;
  logic signed [CELL_W-1:0] cell_x, cell_y;
  logic                     crossed_side, inside_map;
  logic [DIST_W-1:0]        wall_distance;
  logic [COL_W-1:0]         texture_column;
  int                       fail_count, pending_hits;
  bit                       hold_off;

  grid_ray_dda_stepper i_dut (.*);
  grid_ray_dda_checker i_checker (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, hold;
    out_stall = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 600; hold++) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  // one transfer on the input channel, gaps at the start of bursts;
  // valid stays high into the next item of a burst
  task automatic send(logic op, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                      logic [DIR_W-1:0] ddx, logic [DIR_W-1:0] ddy);
    int gap;
    if ($urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op; cam_x <= px; cam_y <= py; dir_x <= ddx; dir_y <= ddy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_map(logic [MAP_W-1:0] w, logic [MAP_W-1:0] h);
    in_valid <= 1'b0;
    while (pending_hits != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= CFG_MAP_WIDTH; cfg_data <= w;
    @(negedge clk);
    cfg_index <= CFG_MAP_HEIGHT; cfg_data <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return DIR_W'($urandom_range(0, 15) - 8);
      default: return DIR_W'($urandom());
    endcase
  endfunction

  initial begin
    int n, s, steps;
    rst = 1'b1; cfg_write = 0; cfg_index = 0; cfg_data = '0;
    in_valid = 0; operation = OP_START; cam_x = '0; cam_y = '0;
    dir_x = '0; dir_y = '0; hold_off = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: step before any start, extreme positions and directions
    send(OP_STEP, '0, '0, '0, '0);
    send(OP_STEP, '0, '0, '0, '0);
    send(OP_START, 24'hFFFFFF, 24'hFFFFFF, 16'h8000, 16'h8000);
    repeat (3) send(OP_STEP, '0, '0, '0, '0);
    send(OP_START, '0, '0, 16'h7FFF, 16'h0000);
    repeat (3) send(OP_STEP, '0, '0, '0, '0);
    send(OP_START, 24'h208000, 24'h108000, 16'h0000, 16'hC000);
    repeat (3) send(OP_STEP, '0, '0, '0, '0);
    send(OP_START, 24'h000001, 24'hFF0000, 16'h0001, 16'hFFFF);
    repeat (3) send(OP_STEP, '0, '0, '0, '0);
    send(OP_START, 24'h010000, 24'h010000, 16'h0000, 16'h0000);
    send(OP_STEP, '0, '0, '0, '0);

    // random rays across map sizes, extremes included
    for (s = 0; s < 5; s++) begin
      case (s)
        0: set_map(9'd1, 9'd256);
        1: set_map(9'd256, 9'd1);
        2: set_map(9'd511, 9'd0);
        default: set_map(MAP_W'($urandom_range(1, 256)), MAP_W'($urandom_range(1, 256)));
      endcase
      if (s == 2) hold_off = 1;
      n = 0;
      while (n < 240) begin
        send($urandom_range(0, 19) == 0 ? OP_STEP : OP_START,
             POS_W'($urandom()), POS_W'($urandom()), rand_dir(), rand_dir());
        steps = $urandom_range(0, 12);
        repeat (steps) send($urandom_range(0, 29) == 0 ? OP_START : OP_STEP,
                            POS_W'($urandom()), POS_W'($urandom()),
                            DIR_W'($urandom()), DIR_W'($urandom()));
        n += steps + 1;
      end
    end

    in_valid <= 1'b0;
    while (pending_hits != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("grid_ray_dda_stepper test passed");
    else $display("grid_ray_dda_stepper test failed");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("grid_ray_dda_stepper test failed");
    $finish;
  end

endmodule

/* grid_ray_dda_stepper.f */
rtl/core/grd_pkg.sv
rtl/core/grd_div.sv
rtl/core/grid_ray_dda_stepper.sv
verif/grid_ray_dda_checker.sv
verif/tb_grid_ray_dda_stepper.sv
